[sv/chacha_pkg.sv]
// Shared types, constants and helpers for the ChaCha20 keystream combiner.
// Used by chacha_arx, chacha_core and chacha20_keystream_xor; no dependencies.
package chacha_pkg;

  localparam int ROUNDS    = 20;
  localparam int RND_W     = (ROUNDS > 2) ? $clog2(ROUNDS) : 1;
  localparam int NUM_WORDS = 16;
  localparam int IDX_W     = $clog2(NUM_WORDS);

  typedef logic [31:0] word_t;
  typedef logic [NUM_WORDS-1:0][31:0] block_t;

  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  // Quarter-round sub-steps, named by their rotate amount
  typedef enum logic [1:0] {
    ARX_R16 = 2'd0,
    ARX_R12 = 2'd1,
    ARX_R8  = 2'd2,
    ARX_R7  = 2'd3
  } arx_step_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_KEY0     = 3'd0,
    REG_KEY1     = 3'd1,
    REG_KEY2     = 3'd2,
    REG_KEY3     = 3'd3,
    REG_NONCE_LO = 3'd4,
    REG_NONCE_HI = 3'd5,
    REG_START    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] ks_idx;
  } core_ctrl_t;

  typedef struct packed {
    logic  done;
    word_t ks_word;
  } core_stat_t;

  function automatic word_t rotl_step(word_t v, arx_step_t step);
    word_t r;
    case (step)
      ARX_R16: r = {v[15:0], v[31:16]};
      ARX_R12: r = {v[19:0], v[31:20]};
      ARX_R8:  r = {v[23:0], v[31:24]};
      ARX_R7:  r = {v[24:0], v[31:25]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

[sv/chacha_arx.sv]
// Shared add-xor-rotate unit: sum = x + y, mix = rotl(z ^ sum, step amount).
// Depends on chacha_pkg.
module chacha_arx (
  input  chacha_pkg::word_t     x,
  input  chacha_pkg::word_t     y,
  input  chacha_pkg::word_t     z,
  input  chacha_pkg::arx_step_t step,
  output chacha_pkg::word_t     sum,
  output chacha_pkg::word_t     mix
);
  import chacha_pkg::*;

  assign sum = x + y;
  assign mix = rotl_step(z ^ sum, step);

endmodule

[sv/chacha_core.sv]
// Block sequencer: working state of sixteen words, one ARX step per cycle,
// then the feed-forward add one word per cycle. Depends on chacha_pkg, chacha_arx.
module chacha_core (
  input  logic                   clk,
  input  logic                   rst,
  input  chacha_pkg::core_ctrl_t ctrl,
  input  chacha_pkg::block_t     init,
  output chacha_pkg::core_stat_t stat
);
  import chacha_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_LOAD, C_ROUND, C_FINAL} cstate_t;

  cstate_t          state;
  block_t           w;
  block_t           w_next;
  block_t           w_upd;
  logic [RND_W-1:0] rnd;
  logic [1:0]       qr;
  arx_step_t        step;
  logic [IDX_W-1:0] k;
  logic             done;

  logic             par;
  logic             half;
  logic [IDX_W-1:0] b_idx;
  logic [IDX_W-1:0] c_idx;
  logic [IDX_W-1:0] d_idx;
  word_t            x;
  word_t            y;
  word_t            z;
  word_t            sum;
  word_t            mix;

  // Rows are rotated one word left after every quarter round, so the
  // quarter round always works on fixed taps: row 0 word 0 and, per round
  // kind, column 0 or the main diagonal of rows 1 to 3.
  assign par   = rnd[0];
  assign half  = (step == ARX_R12) || (step == ARX_R7);
  assign b_idx = par ? IDX_W'(5)  : IDX_W'(4);
  assign c_idx = par ? IDX_W'(10) : IDX_W'(8);
  assign d_idx = par ? IDX_W'(15) : IDX_W'(12);

  always_comb begin
    if (state == C_FINAL) begin
      x = w[k];
      y = init[k];
      z = '0;
    end else if (half) begin
      x = w[c_idx];
      y = w[d_idx];
      z = w[b_idx];
    end else begin
      x = w[0];
      y = w[b_idx];
      z = w[d_idx];
    end
  end

  chacha_arx u_arx (
    .x    (x),
    .y    (y),
    .z    (z),
    .step (step),
    .sum  (sum),
    .mix  (mix)
  );

  always_comb begin
    w_upd = w;
    if (half) begin
      w_upd[c_idx] = sum;
      w_upd[b_idx] = mix;
    end else begin
      w_upd[0]     = sum;
      w_upd[d_idx] = mix;
    end
    w_next = w_upd;
    if (step == ARX_R7) begin
      for (int r = 0; r < 4; r++) begin
        for (int j = 0; j < 4; j++) begin
          w_next[4*r+j] = w_upd[4*r+((j+1)%4)];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      C_LOAD:  w <= init;
      C_ROUND: w <= w_next;
      C_FINAL: w[k] <= sum;
      default: w <= w;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      rnd   <= '0;
      qr    <= '0;
      step  <= ARX_R16;
      k     <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (ctrl.start) state <= C_LOAD;
        end
        C_LOAD: begin
          rnd   <= '0;
          qr    <= '0;
          step  <= ARX_R16;
          state <= C_ROUND;
        end
        C_ROUND: begin
          step <= arx_step_t'(step + 2'd1);
          if (step == ARX_R7) begin
            qr <= qr + 2'd1;
            if (qr == 2'd3) begin
              rnd <= rnd + RND_W'(1);
              if (rnd == RND_W'(ROUNDS - 1)) begin
                k     <= '0;
                state <= C_FINAL;
              end
            end
          end
        end
        C_FINAL: begin
          k <= k + IDX_W'(1);
          if (k == IDX_W'(NUM_WORDS - 1)) begin
            done  <= 1'b1;
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign stat.done    = done;
  assign stat.ks_word = w[ctrl.ks_idx];

endmodule

[sv/chacha20_keystream_xor.sv]
// ChaCha20 keystream combiner: one data byte per word, XORed with keystream.
// Inside a block a byte's result is valid on the cycle after acceptance, one byte per
// cycle while the output is not stalled. A byte opening a new block is held, input closed,
// while one shared ARX unit does one add-xor-rotate per cycle, then the sixteen
// feed-forward adds; its result is registered after that. Reset zeroes the configuration
// and forces a new block on the first byte. Depends on chacha_pkg, chacha_core.
module chacha20_keystream_xor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  output logic        m_tuser,   // [0] exhausted
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import chacha_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_BLOCK, T_EMIT} tstate_t;

  tstate_t           state;
  logic [3:0][63:0]  key;
  logic [63:0]       nonce_lo;
  word_t             nonce_hi;
  logic [63:0]       start_blk;
  word_t             cnt_lo;
  word_t             cnt_hi;
  logic              exhausted_flag;
  logic [6:0]        pos;
  logic [6:0]        pos_inc;
  logic [7:0]        hold_byte;
  logic              hold_last;
  logic [7:0]        ks_byte;
  logic              in_fire;
  logic              cfg_fire;
  logic              out_load;
  logic [63:0]       new_nonce_lo;
  logic [63:0]       new_start;
  block_t            init;
  core_ctrl_t        core_ctrl;
  core_stat_t        core_stat;

  // Hold off bytes while a register write is offered
  assign s_tready  = (state == T_IDLE) && !cfg_valid && (!m_tvalid || m_tready);
  assign cfg_ready = (state == T_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_load  = ((state == T_IDLE) && in_fire && !pos[6]) ||
                     ((state == T_EMIT) && (!m_tvalid || m_tready));

  assign pos_inc = {1'b0, pos[5:0]} + 7'd1;
  assign ks_byte = 8'(core_stat.ks_word >> {pos[1:0], 3'b000});

  assign core_ctrl.start  = in_fire && pos[6];
  assign core_ctrl.ks_idx = pos[5:2];

  always_comb begin
    init[0] = SIGMA0;
    init[1] = SIGMA1;
    init[2] = SIGMA2;
    init[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init[4+2*i] = key[i][31:0];
      init[5+2*i] = key[i][63:32];
    end
    init[12] = cnt_lo;
    init[13] = cnt_hi;
    init[14] = nonce_lo[63:32];
    init[15] = nonce_hi;
  end

  // Counter reload sees the value being written this cycle
  assign new_nonce_lo = (cfg_index == REG_NONCE_LO) ? cfg_data : nonce_lo;
  assign new_start    = (cfg_index == REG_START)    ? cfg_data : start_blk;

  chacha_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (core_ctrl),
    .init (init),
    .stat (core_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= T_IDLE;
      m_tvalid       <= 1'b0;
      m_tdata        <= '0;
      m_tlast        <= 1'b0;
      m_tuser        <= 1'b0;
      key            <= '0;
      nonce_lo       <= '0;
      nonce_hi       <= '0;
      start_blk      <= '0;
      cnt_lo         <= '0;
      cnt_hi         <= '0;
      exhausted_flag <= 1'b0;
      pos            <= 7'd64;
      hold_byte      <= '0;
      hold_last      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) m_tvalid <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (in_fire) begin
            if (pos[6]) begin
              hold_byte <= s_tdata;
              hold_last <= s_tlast;
              state     <= T_BLOCK;
            end else begin
              m_tvalid <= 1'b1;
              m_tdata  <= s_tdata ^ ks_byte;
              m_tlast  <= s_tlast;
              m_tuser  <= exhausted_flag;
              pos      <= pos_inc;
            end
          end
        end
        T_BLOCK: begin
          if (core_stat.done) begin
            // advance the 64-bit block counter; flag a wrap of the high word
            cnt_lo <= cnt_lo + 32'd1;
            if (&cnt_lo) begin
              cnt_hi <= cnt_hi + 32'd1;
              if (&cnt_hi) exhausted_flag <= 1'b1;
            end
            state <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= hold_byte ^ ks_byte;
            m_tlast  <= hold_last;
            m_tuser  <= exhausted_flag;
            pos      <= pos_inc;
            state    <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase

      if (cfg_fire && (cfg_index <= REG_START)) begin
        case (cfg_index) inside
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key[cfg_index[1:0]] <= cfg_data;
          REG_NONCE_LO: nonce_lo  <= cfg_data;
          REG_NONCE_HI: nonce_hi  <= cfg_data[31:0];
          REG_START:    start_blk <= cfg_data;
          default:      ;
        endcase
        cnt_lo         <= new_start[31:0];
        cnt_hi         <= new_nonce_lo[31:0] + new_start[63:32];
        exhausted_flag <= 1'b0;
        pos            <= 7'd64;
      end
    end
  end

  // A byte inside a block gives its word on the next cycle
  a_direct_out: assert property (@(posedge clk) disable iff (rst)
    in_fire && !pos[6] |=> m_tvalid)
    else $error("byte inside block did not produce an output word");

  // Block completion only while a byte waits for it
  a_done_in_block: assert property (@(posedge clk) disable iff (rst)
    core_stat.done |-> state == T_BLOCK)
    else $error("block finished with no byte waiting");

  // Exhausted flag clears only through a configuration write
  a_exhaust_sticky: assert property (@(posedge clk) disable iff (rst)
    exhausted_flag && !cfg_fire |=> exhausted_flag)
    else $error("exhausted flag dropped without a configuration write");

  // Byte position never runs past the end of a block
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos[6] |-> pos[5:0] == 6'd0)
    else $error("byte position out of range");

endmodule

[test/tb_chacha20_keystream_xor.sv]
// Self-checking bench for chacha20_keystream_xor: a directed table, then random
// phases of key/nonce/counter settings and data bytes, scored against a local model.
// Depends on chacha_pkg and the chacha20_keystream_xor RTL.
module tb_chacha20_keystream_xor;
  timeunit 1ns;
  timeprecision 1ps;

  import chacha_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;  // past the register file, ignored
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 16 * ROUNDS + 60;
  localparam int RAND_ITEMS   = 1030;

  typedef struct packed {
    logic [7:0] dat;
    logic       last;
    logic       exh;
  } out_word_t;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [63:0] val;
    logic [7:0]  dat;
    logic        lst;
    logic        fixed;
    logic [7:0]  fixed_byte;
    logic        fixed_exh;
  } dir_row_t;

  localparam int N_DIR = 20;

  // The two typed rows are the first bytes of the all-zero key, nonce and counter block.
  dir_row_t dir_rows [N_DIR] = '{
    '{ROW_BYTE, '0,           '0,                    8'h00, 1'b0, 1'b1, 8'h76, 1'b0},
    '{ROW_BYTE, '0,           '0,                    8'hff, 1'b1, 1'b1, 8'h47, 1'b0},
    '{ROW_BYTE, '0,           '0,                    8'ha5, 1'b0, 1'b0, '0,    1'b0},
    '{ROW_REG,  REG_KEY0,     64'hffff_ffff_ffff_ffff, '0,  1'b0, 1'b0, '0,    1'b0},
    '{ROW_REG,  REG_KEY1,     64'h0123_4567_89ab_cdef, '0,  1'b0, 1'b0, '0,    1'b0},
    '{ROW_REG,  REG_KEY2,     64'hfedc_ba98_7654_3210, '0,  1'b0, 1'b0, '0,    1'b0},
    '{ROW_REG,  REG_KEY3,     64'hffff_ffff_ffff_ffff, '0,  1'b0, 1'b0, '0,    1'b0},
    '{ROW_REG,  REG_NONCE_HI, 64'h0000_0000_ffff_ffff, '0,  1'b0, 1'b0, '0,    1'b0},
    '{ROW_REG,  REG_NONCE_LO, 64'hffff_ffff_0000_0000, '0,  1'b0, 1'b0, '0,    1'b0},
    // both counter words at all ones: the first block wraps the high word
    '{ROW_REG,  REG_START,    64'hffff_ffff_ffff_ffff, '0,  1'b0, 1'b0, '0,    1'b0},
    '{ROW_BYTE, '0,           '0,                    8'h00, 1'b0, 1'b0, '0,    1'b0},
    '{ROW_BYTE, '0,           '0,                    8'hff, 1'b0, 1'b0, '0,    1'b0},
    '{ROW_REG,  REG_UNUSED,   64'h5a5a_5a5a_a5a5_a5a5, '0,  1'b0, 1'b0, '0,    1'b0},
    '{ROW_BYTE, '0,           '0,                    8'h3c, 1'b1, 1'b0, '0,    1'b0},
    // nonce word 0 plus the high counter half wraps to zero without exhausting
    '{ROW_REG,  REG_NONCE_LO, 64'h0000_0000_0000_0001, '0,  1'b0, 1'b0, '0,    1'b0},
    '{ROW_BYTE, '0,           '0,                    8'h80, 1'b0, 1'b0, '0,    1'b0},
    '{ROW_REG,  REG_START,    64'h0000_0000_ffff_ffff, '0,  1'b0, 1'b0, '0,    1'b0},
    '{ROW_BYTE, '0,           '0,                    8'h7f, 1'b1, 1'b0, '0,    1'b0},
    '{ROW_REG,  REG_KEY3,     64'h0000_0000_0000_0000, '0,  1'b0, 1'b0, '0,    1'b0},
    '{ROW_BYTE, '0,           '0,                    8'h00, 1'b0, 1'b0, '0,    1'b0}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_KEY0;
  logic [63:0] cfg_data = '0;

  chacha20_keystream_xor uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cipher model: configuration copy and keystream state
  logic [63:0] key_r [4] = '{default: '0};
  logic [63:0] nonce_lo_r = '0;
  word_t       nonce_hi_r = '0;
  logic [63:0] start_r = '0;
  word_t       ks_words [16];
  word_t       mix [16];
  int unsigned ks_pos = 64;
  word_t       ctr_lo = '0;
  word_t       ctr_hi = '0;
  logic        exh_r = 1'b0;

  out_word_t   pend_q [$];
  out_word_t   got_w;
  int          mismatch_cnt = 0;
  int          burst_left = 0;
  int          rdy_mode = 0;
  int          rdy_left = 0;
  int          idle_cnt = 0;

  function automatic word_t rol32(word_t v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void quarter(int a, int b, int c, int d);
    mix[a] += mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 16);
    mix[c] += mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 12);
    mix[a] += mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 8);
    mix[c] += mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 7);
  endfunction

  function automatic void refill_block();
    word_t seed_w [16];
    int r;
    seed_w[0] = SIGMA0;
    seed_w[1] = SIGMA1;
    seed_w[2] = SIGMA2;
    seed_w[3] = SIGMA3;
    for (int k = 0; k < 4; k++) begin
      seed_w[4 + 2 * k] = key_r[k][31:0];
      seed_w[5 + 2 * k] = key_r[k][63:32];
    end
    seed_w[12] = ctr_lo;
    seed_w[13] = ctr_hi;
    seed_w[14] = nonce_lo_r[63:32];
    seed_w[15] = nonce_hi_r;
    mix = seed_w;
    for (r = 0; r < ROUNDS; r++) begin
      if (r % 2 == 0) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
      end else begin
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
    end
    for (int i = 0; i < 16; i++) ks_words[i] = mix[i] + seed_w[i];
    ctr_lo++;
    if (ctr_lo == 0) begin
      ctr_hi++;
      if (ctr_hi == 0) exh_r = 1'b1;
    end
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [63:0] val);
    case (idx) inside
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_r[idx[1:0]] = val;
      REG_NONCE_LO: nonce_lo_r = val;
      REG_NONCE_HI: nonce_hi_r = val[31:0];
      REG_START:    start_r = val;
      default:      return;
    endcase
    ctr_lo = start_r[31:0];
    ctr_hi = nonce_lo_r[31:0] + start_r[63:32];
    exh_r  = 1'b0;
    ks_pos = 64;
  endfunction

  function automatic out_word_t next_out(logic [7:0] d, logic l);
    out_word_t o;
    word_t sel;
    if (ks_pos >= 64) begin
      refill_block();
      ks_pos = 0;
    end
    sel = ks_words[ks_pos / 4] >> (8 * (ks_pos % 4));
    ks_pos++;
    o.dat  = d ^ sel[7:0];
    o.last = l;
    o.exh  = exh_r;
    return o;
  endfunction

  // Send one byte; the sender runs in bursts with random gaps in between.
  task automatic push_byte(input logic [7:0] d, input logic l, input logic fixed,
                           input out_word_t fixed_w);
    out_word_t w;
    int gap;
    if (cfg_valid) cfg_valid <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    w = next_out(d, l);
    if (fixed) w = fixed_w;
    pend_q.push_back(w);
  endtask

  // Write a register once every outstanding word has come back.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    s_tvalid <= 1'b0;
    while (pend_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  // Score output words and run the receiver's stall pattern
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pend_q.size() == 0) begin
        $display("%0t: unexpected word: out_byte %02h last %0b exhausted %0b",
                 $time, m_tdata, m_tlast, m_tuser);
        mismatch_cnt++;
      end else begin
        got_w = pend_q.pop_front();
        if (m_tdata !== got_w.dat) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, got_w.dat, m_tdata);
          mismatch_cnt++;
        end
        if (m_tlast !== got_w.last) begin
          $display("%0t: last_out expected %0b actual %0b", $time, got_w.last, m_tlast);
          mismatch_cnt++;
        end
        if (m_tuser !== got_w.exh) begin
          $display("%0t: exhausted expected %0b actual %0b", $time, got_w.exh, m_tuser);
          mismatch_cnt++;
        end
      end
    end
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 2);
      rdy_left = $urandom_range(20, 200);
    end
    rdy_left--;
    case (rdy_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= (rdy_left % 3 == 0);
      default: m_tready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // Watchdog: end the run if nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("tb_chacha20_keystream_xor NOT OK");
      $finish;
    end
  end

  initial begin
    out_word_t   fw;
    int unsigned sent;
    int          n;
    logic [2:0]  ri;
    logic [63:0] rv;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < N_DIR; k++) begin
      if (dir_rows[k].kind == ROW_REG) begin
        write_reg(dir_rows[k].idx, dir_rows[k].val);
      end else begin
        fw.dat  = dir_rows[k].fixed_byte;
        fw.last = dir_rows[k].lst;
        fw.exh  = dir_rows[k].fixed_exh;
        push_byte(dir_rows[k].dat, dir_rows[k].lst, dir_rows[k].fixed, fw);
      end
    end

    // Random phases: a few register writes, then a run of bytes
    sent = 0;
    while (sent < RAND_ITEMS) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        ri = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 5))
          0: rv = '0;
          1: rv = '1;
          // park the high counter word at all ones, low word just short of a wrap
          2: rv = {32'hffff_ffff - nonce_lo_r[31:0],
                   32'hffff_ffff - 32'($urandom_range(0, 2))};
          default: rv = {$urandom, $urandom};
        endcase
        write_reg(ri, rv);
      end
      n = $urandom_range(20, 150);
      fw = '0;
      repeat (n) push_byte(8'($urandom), ($urandom_range(0, 7) == 0), 1'b0, fw);
      sent += n;
    end

    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pend_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && pend_q.size() == 0) begin
      $display("tb_chacha20_keystream_xor OK");
    end else begin
      $display("tb_chacha20_keystream_xor NOT OK");
    end
    $finish;
  end

endmodule
